// ----- rtl/rlphg_pkg.sv -----
// Package for the RFC 4175 line packet header generator.
// Holds register indexes, reset values and fixed header constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlphg_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PIXEL  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PAD     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TS      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_IP      = 4'd7;

  localparam logic [11:0] RST_LINE_WIDTH   = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [2:0]  RST_BYTES_PIXEL  = 3'd3;
  localparam logic [7:0]  RST_LINE_PAD     = 8'd64;
  localparam logic [31:0] RST_BASE_TS      = 32'd0;
  localparam logic [15:0] RST_START_SEQ    = 16'd0;
  localparam logic [31:0] RST_SOURCE_IP    = 32'hC0A8_0101;
  localparam logic [31:0] RST_DEST_IP      = 32'hC0A8_0102;

  localparam int unsigned TICKS_PER_FRAME_DEF = 3000;

  localparam int unsigned LINE_STORED_BIT = 30;

  localparam logic [15:0] UDP_RTP_HDR_BYTES = 16'd28;
  localparam logic [15:0] IP_HDR_BYTES      = 16'd20;
  localparam logic [15:0] IP_VER_IHL_TOS    = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO      = 16'h4011;
  localparam logic [15:0] CSUM_INIT         = IP_VER_IHL_TOS + IP_TTL_PROTO;

endpackage : rlphg_pkg

`default_nettype wire

// ----- rtl/rfc4175_line_packet_header_gen.sv -----
// Top level of the RFC 4175 line packet header generator.
// Uses rlphg_pkg for register indexes, reset values and header constants.
//
// Usage: each input beat on in_* carries one capture status word. When bit 30
// (line stored) is set, the block produces one output beat with the variable
// RTP/UDP/IPv4 header fields for the current line and then advances its line
// and sequence counters, and at a frame end its timestamp and buffer select.
// When bit 30 is clear the beat is consumed and nothing is produced or changed.
// A line-stored beat passes through the multiply, stride, UDP, IP, checksum
// and done states to the output register. All sums run on one shared 16-bit
// adder with an optional end-around carry: stride, UDP length, IP length and
// five checksum accumulation steps, so no new beat is accepted until the last
// one is through. A beat without the line-stored bit leaves the sequencer idle.
// in_stall is high while the sequencer is busy. A finished result sits in the
// output register while a new beat is accepted and worked on; if the receiver
// still stalls when the next result is ready, the sequencer waits.
// Reset (synchronous, active low) loads all configuration registers with their
// defaults, clears the line counter and buffer select, and loads the sequence
// and timestamp from the defaults. Configuration must be written while idle only; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module rfc4175_line_packet_header_gen #(
  parameter int unsigned TICKS_PER_FRAME = rlphg_pkg::TICKS_PER_FRAME_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [rlphg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlphg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      in_status_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_buffer_select,
  output logic [24:0]                           out_payload_offset,
  output logic [11:0]                           out_line_number,
  output logic [15:0]                           out_line_length,
  output logic [15:0]                           out_rtp_sequence,
  output logic [31:0]                           out_rtp_timestamp,
  output logic                                  out_marker,
  output logic [15:0]                           out_udp_length,
  output logic [15:0]                           out_ip_total_length,
  output logic [15:0]                           out_ip_checksum
);

  import rlphg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STRIDE,
    ST_UDP,
    ST_IP,
    ST_CSUM,
    ST_DONE
  } state_t;

  state_t      state_r;
  logic [2:0]  word_cnt_r;

  logic [11:0] line_width_r;
  logic [11:0] frame_height_r;
  logic [2:0]  bytes_pixel_r;
  logic [7:0]  line_pad_r;
  logic [31:0] source_ip_r;
  logic [31:0] dest_ip_r;

  logic [11:0] line_cnt_r;
  logic [15:0] seq_cnt_r;
  logic [31:0] frame_ts_r;
  logic        buf_toggle_r;

  logic [14:0] line_bytes_r;
  logic [11:0] factor_r;
  logic        last_r;
  logic [15:0] stride_r;
  logic [24:0] offset_r;
  logic [15:0] udp_len_r;
  logic [15:0] ip_len_r;
  logic [15:0] acc_r;

  logic        out_valid_r;
  logic        out_buf_sel_r;
  logic [24:0] out_offset_r;
  logic [11:0] out_line_r;
  logic [15:0] out_len_r;
  logic [15:0] out_seq_r;
  logic [31:0] out_ts_r;
  logic        out_marker_r;
  logic [15:0] out_udp_r;
  logic [15:0] out_ip_r;
  logic [15:0] out_csum_r;

  logic [15:0] alu_a;
  logic [15:0] alu_b;
  logic        alu_eac;
  logic [16:0] alu_sum;
  logic [15:0] alu_y;

  logic        in_take;
  logic        out_free;
  logic        last_nxt;
  logic [11:0] factor_nxt;
  logic [12:0] line_inc;
  logic        frame_end;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Shared adder; the end-around carry gives ones'-complement addition.
  always_comb begin
    alu_a   = acc_r;
    alu_b   = 16'd0;
    alu_eac = 1'b0;
    case (state_r)
      ST_STRIDE: begin
        alu_a = {1'b0, line_bytes_r};
        alu_b = {8'd0, line_pad_r};
      end
      ST_UDP: begin
        alu_a = {1'b0, line_bytes_r};
        alu_b = UDP_RTP_HDR_BYTES;
      end
      ST_IP: begin
        alu_a = udp_len_r;
        alu_b = IP_HDR_BYTES;
      end
      ST_CSUM: begin
        alu_eac = 1'b1;
        case (word_cnt_r)
          3'd0:    alu_b = ip_len_r;
          3'd1:    alu_b = source_ip_r[31:16];
          3'd2:    alu_b = source_ip_r[15:0];
          3'd3:    alu_b = dest_ip_r[31:16];
          default: alu_b = dest_ip_r[15:0];
        endcase
      end
      default: begin
        alu_a = acc_r;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};
  assign alu_y   = alu_eac ? (alu_sum[15:0] + {15'd0, alu_sum[16]}) : alu_sum[15:0];

  assign last_nxt = (frame_height_r != 12'd0) && (line_cnt_r == (frame_height_r - 12'd1));

  always_comb begin
    if (line_cnt_r == 12'd0) begin
      factor_nxt = 12'd1;
    end else if (last_nxt) begin
      factor_nxt = frame_height_r - 12'd2;
    end else begin
      factor_nxt = line_cnt_r;
    end
  end

  assign line_inc  = {1'b0, line_cnt_r} + 13'd1;
  assign frame_end = (line_inc >= {1'b0, frame_height_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      word_cnt_r     <= 3'd0;
      line_width_r   <= RST_LINE_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      bytes_pixel_r  <= RST_BYTES_PIXEL;
      line_pad_r     <= RST_LINE_PAD;
      source_ip_r    <= RST_SOURCE_IP;
      dest_ip_r      <= RST_DEST_IP;
      line_cnt_r     <= 12'd0;
      seq_cnt_r      <= RST_START_SEQ;
      frame_ts_r     <= RST_BASE_TS;
      buf_toggle_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LINE_WIDTH:   line_width_r   <= cfg_data[11:0];
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data[11:0];
          REG_BYTES_PIXEL:  bytes_pixel_r  <= cfg_data[2:0];
          REG_LINE_PAD:     line_pad_r     <= cfg_data[7:0];
          REG_BASE_TS:      frame_ts_r     <= cfg_data[31:0];
          REG_START_SEQ:    seq_cnt_r      <= cfg_data[15:0];
          REG_SOURCE_IP:    source_ip_r    <= cfg_data[31:0];
          REG_DEST_IP:      dest_ip_r      <= cfg_data[31:0];
          default: begin
          end
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_take && in_status_word[LINE_STORED_BIT]) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          line_bytes_r <= 15'(line_width_r * bytes_pixel_r);
          factor_r     <= factor_nxt;
          last_r       <= last_nxt;
          state_r      <= ST_STRIDE;
        end
        ST_STRIDE: begin
          stride_r <= alu_y;
          state_r  <= ST_UDP;
        end
        ST_UDP: begin
          udp_len_r <= alu_y;
          offset_r  <= 25'(stride_r * factor_r);
          state_r   <= ST_IP;
        end
        ST_IP: begin
          ip_len_r   <= alu_y;
          acc_r      <= CSUM_INIT;
          word_cnt_r <= 3'd0;
          state_r    <= ST_CSUM;
        end
        ST_CSUM: begin
          acc_r      <= alu_y;
          word_cnt_r <= word_cnt_r + 3'd1;
          if (word_cnt_r == 3'd4) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_buf_sel_r <= buf_toggle_r;
            out_offset_r  <= offset_r;
            out_line_r    <= line_cnt_r;
            out_len_r     <= {1'b0, line_bytes_r};
            out_seq_r     <= seq_cnt_r;
            out_ts_r      <= frame_ts_r;
            out_marker_r  <= last_r;
            out_udp_r     <= udp_len_r;
            out_ip_r      <= ip_len_r;
            out_csum_r    <= ~acc_r;
            seq_cnt_r     <= seq_cnt_r + 16'd1;
            if (frame_end) begin
              line_cnt_r   <= 12'd0;
              buf_toggle_r <= ~buf_toggle_r;
              frame_ts_r   <= frame_ts_r + 32'(TICKS_PER_FRAME);
            end else begin
              line_cnt_r <= line_inc[11:0];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_buffer_select   = out_buf_sel_r;
  assign out_payload_offset  = out_offset_r;
  assign out_line_number     = out_line_r;
  assign out_line_length     = out_len_r;
  assign out_rtp_sequence    = out_seq_r;
  assign out_rtp_timestamp   = out_ts_r;
  assign out_marker          = out_marker_r;
  assign out_udp_length      = out_udp_r;
  assign out_ip_total_length = out_ip_r;
  assign out_ip_checksum     = out_csum_r;

endmodule : rfc4175_line_packet_header_gen

`default_nettype wire
